// File: rtl/core/dlr_pkg.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer package
// Shared widths, operation codes and the command record that travels from
// the front end through the command queue to the stepping engine.
// ----------------------------------------------------------------------------
package dlr_pkg;

    // Coordinate and fixed-point widths.
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;
    localparam int CNT_BITS   = COORD_BITS + 1;
    localparam int QUOT_BITS  = FRAC_BITS + 1;
    localparam int COLOR_BITS = 24;

    // Divider iteration counter: one quotient bit per cycle.
    localparam int DIV_CNT_BITS = $clog2(FRAC_BITS + 1);

    // Command queue depth.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Reset value of the color register.
    localparam logic [COLOR_BITS-1:0] COLOR_RESET = COLOR_BITS'(8'hFF);

    // Operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Classified command as produced by the front end.
    typedef struct packed {
        logic                  op;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] abs_dx;
        logic [COORD_BITS-1:0] abs_dy;
        logic                  neg_x;
        logic                  neg_y;
        logic [COORD_BITS-1:0] steps;
    } cmd_t;

endpackage

// File: rtl/core/dlr_front.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer front end
// Accepts input transactions, works out the deltas, their magnitudes and
// signs and the step count, and pushes the classified command to the queue.
// ----------------------------------------------------------------------------
module dlr_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [dlr_pkg::COORD_BITS-1:0] x_start,
    input  logic [dlr_pkg::COORD_BITS-1:0] y_start,
    input  logic [dlr_pkg::COORD_BITS-1:0] x_end,
    input  logic [dlr_pkg::COORD_BITS-1:0] y_end,
    output logic                          push,
    output dlr_pkg::cmd_t                 push_cmd,
    input  logic                          queue_full
);

    logic                              valid_reg;
    logic                              valid_next;
    dlr_pkg::cmd_t                     cmd_reg;
    dlr_pkg::cmd_t                     cmd_next;
    logic                              accept;
    logic signed [dlr_pkg::COORD_BITS:0] dx;
    logic signed [dlr_pkg::COORD_BITS:0] dy;
    logic [dlr_pkg::COORD_BITS-1:0]    abs_dx;
    logic [dlr_pkg::COORD_BITS-1:0]    abs_dy;

    // Hold the input while the stage is full and the queue cannot take it.
    assign in_stall = valid_reg && queue_full;
    assign accept   = in_valid && !in_stall;
    assign push     = valid_reg && !queue_full;
    assign push_cmd = cmd_reg;

    // Classify: signed deltas, magnitudes and the major-axis step count.
    always_comb
    begin
        dx     = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
        dy     = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
        abs_dx = dx[dlr_pkg::COORD_BITS] ? dlr_pkg::COORD_BITS'(-dx)
                                         : dx[dlr_pkg::COORD_BITS-1:0];
        abs_dy = dy[dlr_pkg::COORD_BITS] ? dlr_pkg::COORD_BITS'(-dy)
                                         : dy[dlr_pkg::COORD_BITS-1:0];
        cmd_next.op      = operation;
        cmd_next.x_start = x_start;
        cmd_next.y_start = y_start;
        cmd_next.abs_dx  = abs_dx;
        cmd_next.abs_dy  = abs_dy;
        cmd_next.neg_x   = dx[dlr_pkg::COORD_BITS];
        cmd_next.neg_y   = dy[dlr_pkg::COORD_BITS];
        cmd_next.steps   = (abs_dx > abs_dy) ? abs_dx : abs_dy;
    end

    // Stage occupancy.
    always_comb
    begin
        valid_next = accept || (valid_reg && queue_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Command payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// File: rtl/core/dlr_queue.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer command queue
// A short first-in first-out queue that decouples the front end from the
// stepping engine.
// ----------------------------------------------------------------------------
module dlr_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dlr_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          pop_valid,
    output dlr_pkg::cmd_t pop_cmd
);

    dlr_pkg::cmd_t                  mem [dlr_pkg::QUEUE_DEPTH];
    logic [dlr_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [dlr_pkg::QUEUE_AW-1:0]   wr_ptr_next;
    logic [dlr_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [dlr_pkg::QUEUE_AW-1:0]   rd_ptr_next;
    logic [dlr_pkg::QUEUE_AW:0]     count_reg;
    logic [dlr_pkg::QUEUE_AW:0]     count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full      = (count_reg == (dlr_pkg::QUEUE_AW + 1)'(dlr_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Pointer and fill-count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/core/dlr_back.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer stepping engine
// Takes commands from the queue. A start command loads the accumulators and
// runs a bit-serial divider for both increments; a tick command emits one
// pixel into the output register and advances the accumulators.
// ----------------------------------------------------------------------------
module dlr_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    input  dlr_pkg::cmd_t                   cmd,
    output logic                            cmd_pop,
    input  logic [dlr_pkg::COLOR_BITS-1:0]  color,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [dlr_pkg::COORD_BITS-1:0]  pixel_x,
    output logic [dlr_pkg::COORD_BITS-1:0]  pixel_y,
    output logic [dlr_pkg::COLOR_BITS-1:0]  pixel_color,
    output logic                            last_pixel
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    localparam logic signed [dlr_pkg::ACC_BITS:0] HALF_ULP =
        (dlr_pkg::ACC_BITS + 1)'(1) << (dlr_pkg::FRAC_BITS - 1);

    logic                                    state_reg, state_next;
    logic                                    busy_reg, busy_next;
    logic signed [dlr_pkg::ACC_BITS-1:0]     acc_x_reg, acc_x_next;
    logic signed [dlr_pkg::ACC_BITS-1:0]     acc_y_reg, acc_y_next;
    logic signed [dlr_pkg::ACC_BITS-1:0]     step_x_reg, step_x_next;
    logic signed [dlr_pkg::ACC_BITS-1:0]     step_y_reg, step_y_next;
    logic [dlr_pkg::CNT_BITS-1:0]            pixels_left_reg, pixels_left_next;
    logic [dlr_pkg::CNT_BITS-1:0]            rem_x_reg, rem_x_next;
    logic [dlr_pkg::CNT_BITS-1:0]            rem_y_reg, rem_y_next;
    logic [dlr_pkg::QUOT_BITS-1:0]           quot_x_reg, quot_x_next;
    logic [dlr_pkg::QUOT_BITS-1:0]           quot_y_reg, quot_y_next;
    logic [dlr_pkg::COORD_BITS-1:0]          divisor_reg, divisor_next;
    logic                                    neg_x_reg, neg_x_next;
    logic                                    neg_y_reg, neg_y_next;
    logic [dlr_pkg::DIV_CNT_BITS-1:0]        div_cnt_reg, div_cnt_next;
    logic                                    out_valid_reg, out_valid_next;
    logic [dlr_pkg::COORD_BITS-1:0]          pixel_x_reg, pixel_x_next;
    logic [dlr_pkg::COORD_BITS-1:0]          pixel_y_reg, pixel_y_next;
    logic [dlr_pkg::COLOR_BITS-1:0]          color_reg, color_next;
    logic                                    last_reg, last_next;
    logic                                    emit;
    logic                                    out_room;
    logic [dlr_pkg::CNT_BITS-1:0]            shift_x;
    logic [dlr_pkg::CNT_BITS-1:0]            shift_y;
    logic                                    bit_x;
    logic                                    bit_y;
    logic [dlr_pkg::QUOT_BITS-1:0]           quot_x_new;
    logic [dlr_pkg::QUOT_BITS-1:0]           quot_y_new;
    logic signed [dlr_pkg::ACC_BITS-1:0]     mag_x;
    logic signed [dlr_pkg::ACC_BITS-1:0]     mag_y;

    // Round an accumulator to the nearest pixel and clamp it to the raster.
    function automatic logic [dlr_pkg::COORD_BITS-1:0] to_pixel
    (
        input logic signed [dlr_pkg::ACC_BITS-1:0] acc
    );
        logic signed [dlr_pkg::ACC_BITS:0] r;
        logic [dlr_pkg::COORD_BITS:0]      p;
        r = $signed({acc[dlr_pkg::ACC_BITS-1], acc}) + HALF_ULP;
        p = r[dlr_pkg::ACC_BITS-1:dlr_pkg::FRAC_BITS];
        if (r[dlr_pkg::ACC_BITS])
        begin
            to_pixel = '0;
        end
        else if (p[dlr_pkg::COORD_BITS])
        begin
            to_pixel = '1;
        end
        else
        begin
            to_pixel = p[dlr_pkg::COORD_BITS-1:0];
        end
    endfunction

    assign out_room    = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = color_reg;
    assign last_pixel  = last_reg;

    // One restoring-division step for both axes. The first step compares
    // the magnitude itself; later steps shift the remainder left first.
    always_comb
    begin
        shift_x = (div_cnt_reg == '0) ? rem_x_reg : {rem_x_reg[dlr_pkg::CNT_BITS-2:0], 1'b0};
        shift_y = (div_cnt_reg == '0) ? rem_y_reg : {rem_y_reg[dlr_pkg::CNT_BITS-2:0], 1'b0};
        bit_x   = shift_x >= {1'b0, divisor_reg};
        bit_y   = shift_y >= {1'b0, divisor_reg};
        quot_x_new = {quot_x_reg[dlr_pkg::QUOT_BITS-2:0], bit_x};
        quot_y_new = {quot_y_reg[dlr_pkg::QUOT_BITS-2:0], bit_y};
        mag_x = $signed(dlr_pkg::ACC_BITS'(quot_x_new));
        mag_y = $signed(dlr_pkg::ACC_BITS'(quot_y_new));
    end

    // Sequencer: command dispatch, division steps and pixel emission.
    always_comb
    begin
        state_next       = state_reg;
        busy_next        = busy_reg;
        acc_x_next       = acc_x_reg;
        acc_y_next       = acc_y_reg;
        step_x_next      = step_x_reg;
        step_y_next      = step_y_reg;
        pixels_left_next = pixels_left_reg;
        rem_x_next       = rem_x_reg;
        rem_y_next       = rem_y_reg;
        quot_x_next      = quot_x_reg;
        quot_y_next      = quot_y_reg;
        divisor_next     = divisor_reg;
        neg_x_next       = neg_x_reg;
        neg_y_next       = neg_y_reg;
        div_cnt_next     = div_cnt_reg;
        cmd_pop          = 1'b0;
        emit             = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == dlr_pkg::OP_START)
                    begin
                        // A start abandons any line in progress.
                        cmd_pop          = 1'b1;
                        busy_next        = 1'b1;
                        acc_x_next       = $signed({1'b0, cmd.x_start,
                                                    {dlr_pkg::FRAC_BITS{1'b0}}});
                        acc_y_next       = $signed({1'b0, cmd.y_start,
                                                    {dlr_pkg::FRAC_BITS{1'b0}}});
                        pixels_left_next = {1'b0, cmd.steps} + 1'b1;
                        step_x_next      = '0;
                        step_y_next      = '0;
                        rem_x_next       = {1'b0, cmd.abs_dx};
                        rem_y_next       = {1'b0, cmd.abs_dy};
                        quot_x_next      = '0;
                        quot_y_next      = '0;
                        divisor_next     = cmd.steps;
                        neg_x_next       = cmd.neg_x;
                        neg_y_next       = cmd.neg_y;
                        div_cnt_next     = '0;
                        // A zero-length line keeps zero increments.
                        if (cmd.steps != '0)
                        begin
                            state_next = ST_DIV;
                        end
                    end
                    else if (out_room)
                    begin
                        // A tick with no line in progress is dropped without a result.
                        cmd_pop = 1'b1;
                        if (busy_reg)
                        begin
                            emit             = 1'b1;
                            acc_x_next       = acc_x_reg + step_x_reg;
                            acc_y_next       = acc_y_reg + step_y_reg;
                            pixels_left_next = pixels_left_reg - 1'b1;
                            if (pixels_left_reg == dlr_pkg::CNT_BITS'(1))
                            begin
                                busy_next = 1'b0;
                            end
                        end
                    end
                end
            end
            ST_DIV:
            begin
                rem_x_next  = bit_x ? shift_x - {1'b0, divisor_reg} : shift_x;
                rem_y_next  = bit_y ? shift_y - {1'b0, divisor_reg} : shift_y;
                quot_x_next = quot_x_new;
                quot_y_next = quot_y_new;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == dlr_pkg::DIV_CNT_BITS'(dlr_pkg::FRAC_BITS))
                begin
                    step_x_next = neg_x_reg ? -mag_x : mag_x;
                    step_y_next = neg_y_reg ? -mag_y : mag_y;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register update.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        pixel_x_next   = pixel_x_reg;
        pixel_y_next   = pixel_y_reg;
        color_next     = color_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            pixel_x_next   = to_pixel(acc_x_reg);
            pixel_y_next   = to_pixel(acc_y_reg);
            color_next     = color;
            last_next      = (pixels_left_reg == dlr_pkg::CNT_BITS'(1));
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            busy_reg        <= 1'b0;
            pixels_left_reg <= '0;
            div_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            busy_reg        <= busy_next;
            pixels_left_reg <= pixels_left_next;
            div_cnt_reg     <= div_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        acc_x_reg   <= acc_x_next;
        acc_y_reg   <= acc_y_next;
        step_x_reg  <= step_x_next;
        step_y_reg  <= step_y_next;
        rem_x_reg   <= rem_x_next;
        rem_y_reg   <= rem_y_next;
        quot_x_reg  <= quot_x_next;
        quot_y_reg  <= quot_y_next;
        divisor_reg <= divisor_next;
        neg_x_reg   <= neg_x_next;
        neg_y_reg   <= neg_y_next;
        pixel_x_reg <= pixel_x_next;
        pixel_y_reg <= pixel_y_next;
        color_reg   <= color_next;
        last_reg    <= last_next;
    end

    // The divider only runs for a line that has pixels to give.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (busy_reg && pixels_left_reg != '0))
        else $error("divider running without an active line");

    // An active line always has at least one pixel left.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pixels_left_reg != '0))
        else $error("active line with no pixels left");

    // A pixel is never written over one that is still held.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || !out_stall))
        else $error("pixel emitted into a stalled output register");

    // A line ends only by emitting its flagged last pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> (out_valid_reg && last_reg))
        else $error("line ended without its last pixel");

endmodule

// File: rtl/core/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer
// Top level: color register, front end, command queue and stepping engine.
// ----------------------------------------------------------------------------
// A start transaction (operation 0) loads two endpoints and produces no
// pixel. It occupies the stepping engine while it takes the command and
// then while a bit-serial divider forms both increments, one quotient bit
// per cycle; a zero-length line skips the divider. Each tick transaction
// (operation 1) then emits one pixel per cycle from the engine into the
// output register while the output does not stall; the last of the
// steps+1 pixels carries last_pixel. A tick with no line in progress is
// consumed without a result, and a start abandons the current line. A
// four-entry command queue lets the input keep accepting while the
// divider runs or the output stalls. The line color register is written on
// the cfg channel, which is always ready, and should be written only while
// no line is being drawn.
module dda_line_rasterizer
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dlr_pkg::COLOR_BITS-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            operation,
    input  logic [dlr_pkg::COORD_BITS-1:0]  x_start,
    input  logic [dlr_pkg::COORD_BITS-1:0]  y_start,
    input  logic [dlr_pkg::COORD_BITS-1:0]  x_end,
    input  logic [dlr_pkg::COORD_BITS-1:0]  y_end,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [dlr_pkg::COORD_BITS-1:0]  pixel_x,
    output logic [dlr_pkg::COORD_BITS-1:0]  pixel_y,
    output logic [dlr_pkg::COLOR_BITS-1:0]  pixel_color,
    output logic                            last_pixel
);

    logic [dlr_pkg::COLOR_BITS-1:0] line_color_reg;
    logic [dlr_pkg::COLOR_BITS-1:0] line_color_next;
    logic                           push;
    dlr_pkg::cmd_t                  push_cmd;
    logic                           queue_full;
    logic                           pop;
    logic                           pop_valid;
    dlr_pkg::cmd_t                  pop_cmd;

    // Configuration write: always accepted.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        line_color_next = (cfg_valid && cfg_ready) ? cfg_data : line_color_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_color_reg <= dlr_pkg::COLOR_RESET;
        end
        else
        begin
            line_color_reg <= line_color_next;
        end
    end

    // Front end: accepts and classifies input transactions.
    dlr_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .push       (push),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    // Command queue between the front end and the stepping engine.
    dlr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd)
    );

    // Stepping engine with the increment divider and output register.
    dlr_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (pop_valid),
        .cmd         (pop_cmd),
        .cmd_pop     (pop),
        .color       (line_color_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel)
    );

endmodule
